// File: rtl/core/pcps_pkg.sv
// shared types, constants and the arctangent table for the planar scan block
`default_nettype none
package pcps_pkg;

   localparam int NUM_BINS_DEF = 360;
   localparam int CORDIC_STEPS = 32;
   localparam int CORDIC_SCALE = 30;
   localparam int VEC_W        = 49;
   localparam int RANGE_W      = 16;
   localparam int COORD_W      = 16;
   localparam int SEL_W        = 9;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FLOOR    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CEILING  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DIST = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DIST = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_MIN = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_MAX = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_KEEP_FAR = 3'd6;

   // operation codes
   localparam logic [1:0] FN_POINT = 2'd0;
   localparam logic [1:0] FN_READ  = 2'd1;
   localparam logic [1:0] FN_CLEAR = 2'd2;

   typedef struct packed {
      logic load;
      logic square;
      logic sum;
      logic step;
      logic bin;
      logic rd_sel;
      logic rd_bin;
      logic wr_acc;
      logic wr_clr;
      logic rsp_point;
      logic rsp_read;
      logic rsp_zero;
   } cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       in_band;
   } status_type;

   function automatic logic [31:0] atan_turn(input logic [4:0] i);
      logic [31:0] a;
      case (i)
         5'd0:  a = 32'h20000000;
         5'd1:  a = 32'h12E4051E;
         5'd2:  a = 32'h09FB385B;
         5'd3:  a = 32'h051111D4;
         5'd4:  a = 32'h028B0D43;
         5'd5:  a = 32'h0145D7E1;
         5'd6:  a = 32'h00A2F61E;
         5'd7:  a = 32'h00517C55;
         5'd8:  a = 32'h0028BE53;
         5'd9:  a = 32'h00145F2F;
         5'd10: a = 32'h000A2F98;
         5'd11: a = 32'h000517CC;
         5'd12: a = 32'h00028BE6;
         5'd13: a = 32'h000145F3;
         5'd14: a = 32'h0000A2F9;
         5'd15: a = 32'h0000517C;
         5'd16: a = 32'h000028BE;
         5'd17: a = 32'h0000145F;
         5'd18: a = 32'h00000A2F;
         5'd19: a = 32'h00000517;
         5'd20: a = 32'h0000028B;
         5'd21: a = 32'h00000145;
         5'd22: a = 32'h000000A2;
         5'd23: a = 32'h00000051;
         5'd24: a = 32'h00000028;
         5'd25: a = 32'h00000014;
         5'd26: a = 32'h0000000A;
         5'd27: a = 32'h00000005;
         5'd28: a = 32'h00000002;
         5'd29: a = 32'h00000001;
         default: a = 32'h00000000;
      endcase
      return a;
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/point_cloud_to_planar_scan.sv
// top level: planar range scan from ground-frame points
//
//   channel   ports                     handshake
//   request   start, req_*              taken when start && !busy
//   response  rsp_*                     rsp_strobe for one cycle, no stall
//   csr       csr_we, csr_index, csr_*  write at any edge with csr_we
//
// a point in the height band goes from accept to strobe through 32 cordic
// iterations, each reusing the same shifters and adders (the root runs its 16
// steps alongside), then bin multiply, ram read and read-modify-write. a read
// answers from one ram read, a clear sweeps every bin. after reset busy stays
// high while the bin ram is swept empty; csr writes are taken then.
`default_nettype none
module point_cloud_to_planar_scan #(
   parameter int NUM_BINS = pcps_pkg::NUM_BINS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic [1:0]                           req_func,
   input  wire logic signed [pcps_pkg::COORD_W-1:0]  req_point_x,
   input  wire logic signed [pcps_pkg::COORD_W-1:0]  req_point_y,
   input  wire logic signed [pcps_pkg::COORD_W-1:0]  req_point_z,
   input  wire logic [pcps_pkg::SEL_W-1:0]           req_bin_select,
   input  wire logic                                 csr_we,
   input  wire logic [pcps_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [pcps_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output logic                                      rsp_strobe,
   output logic                                      rsp_accepted,
   output logic [pcps_pkg::SEL_W-1:0]                rsp_bin_index,
   output logic [pcps_pkg::RANGE_W-1:0]              rsp_range_mm,
   output logic                                      rsp_range_valid
);
   import pcps_pkg::*;

   localparam int CNT_W = ($clog2(NUM_BINS) > 5) ? $clog2(NUM_BINS) : 5;

   cmd_type          cmd;
   status_type       status;
   logic [CNT_W-1:0] cnt;

   pcps_ctrl #(
      .NUM_BINS (NUM_BINS),
      .CNT_W    (CNT_W)
   ) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd),
      .cnt    (cnt)
   );

   pcps_dp #(
      .NUM_BINS (NUM_BINS),
      .CNT_W    (CNT_W)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .cnt             (cnt),
      .status          (status),
      .req_func        (req_func),
      .req_point_x     (req_point_x),
      .req_point_y     (req_point_y),
      .req_point_z     (req_point_z),
      .req_bin_select  (req_bin_select),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_strobe      (rsp_strobe),
      .rsp_accepted    (rsp_accepted),
      .rsp_bin_index   (rsp_bin_index),
      .rsp_range_mm    (rsp_range_mm),
      .rsp_range_valid (rsp_range_valid)
   );

endmodule
`default_nettype wire

// File: rtl/core/pcps_ram.sv
// generic single-write, single-read ram with registered read
`default_nettype none
module pcps_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 360
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// File: rtl/core/pcps_ctrl.sv
// controller state machine sequencing decode, iterations, bin access and clearing
`default_nettype none
module pcps_ctrl #(
   parameter int NUM_BINS = pcps_pkg::NUM_BINS_DEF,
   parameter int CNT_W    = 9
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire pcps_pkg::status_type status,
   output pcps_pkg::cmd_type         cmd,
   output logic [CNT_W-1:0]          cnt
);
   import pcps_pkg::*;

   localparam logic [3:0] S_CLR_RST  = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_DEC      = 4'd2;
   localparam logic [3:0] S_SUM      = 4'd3;
   localparam logic [3:0] S_ITER     = 4'd4;
   localparam logic [3:0] S_BIN      = 4'd5;
   localparam logic [3:0] S_RD       = 4'd6;
   localparam logic [3:0] S_WR       = 4'd7;
   localparam logic [3:0] S_RRSP     = 4'd8;
   localparam logic [3:0] S_CLR_ITEM = 4'd9;

   localparam logic [CNT_W-1:0] LAST_BIN  = CNT_W'(NUM_BINS - 1);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(CORDIC_STEPS - 1);

   logic [3:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         S_CLR_RST: begin
            cmd.wr_clr = 1'b1;
            cnt_in     = cnt_ff + 1'b1;
            if (cnt_ff == LAST_BIN) begin
               cnt_in   = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            case (status.func)
               FN_POINT: begin
                  if (status.in_band) begin
                     cmd.square = 1'b1;
                     state_in   = S_SUM;
                  end else begin
                     cmd.rsp_zero = 1'b1;
                     state_in     = S_IDLE;
                  end
               end
               FN_READ: begin
                  cmd.rd_sel = 1'b1;
                  state_in   = S_RRSP;
               end
               FN_CLEAR: begin
                  cnt_in   = '0;
                  state_in = S_CLR_ITEM;
               end
               default: begin
                  cmd.rsp_zero = 1'b1;
                  state_in     = S_IDLE;
               end
            endcase
         end
         S_SUM: begin
            cmd.sum  = 1'b1;
            cnt_in   = '0;
            state_in = S_ITER;
         end
         S_ITER: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == LAST_STEP) begin
               cnt_in   = '0;
               state_in = S_BIN;
            end
         end
         S_BIN: begin
            cmd.bin  = 1'b1;
            state_in = S_RD;
         end
         S_RD: begin
            cmd.rd_bin = 1'b1;
            state_in   = S_WR;
         end
         S_WR: begin
            cmd.wr_acc    = 1'b1;
            cmd.rsp_point = 1'b1;
            state_in      = S_IDLE;
         end
         S_RRSP: begin
            cmd.rsp_read = 1'b1;
            state_in     = S_IDLE;
         end
         S_CLR_ITEM: begin
            cmd.wr_clr = 1'b1;
            cnt_in     = cnt_ff + 1'b1;
            if (cnt_ff == LAST_BIN) begin
               cnt_in       = '0;
               cmd.rsp_zero = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            cnt_in   = '0;
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR_RST;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign cnt  = cnt_ff;

endmodule
`default_nettype wire

// File: rtl/core/pcps_dp.sv
// datapath: registers, squares, iterative root, cordic angle, clipping and bin store
`default_nettype none
module pcps_dp #(
   parameter int NUM_BINS = pcps_pkg::NUM_BINS_DEF,
   parameter int CNT_W    = 9
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire pcps_pkg::cmd_type                    cmd,
   input  wire logic [CNT_W-1:0]                     cnt,
   output pcps_pkg::status_type                      status,
   input  wire logic [1:0]                           req_func,
   input  wire logic signed [pcps_pkg::COORD_W-1:0]  req_point_x,
   input  wire logic signed [pcps_pkg::COORD_W-1:0]  req_point_y,
   input  wire logic signed [pcps_pkg::COORD_W-1:0]  req_point_z,
   input  wire logic [pcps_pkg::SEL_W-1:0]           req_bin_select,
   input  wire logic                                 csr_we,
   input  wire logic [pcps_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [pcps_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output logic                                      rsp_strobe,
   output logic                                      rsp_accepted,
   output logic [pcps_pkg::SEL_W-1:0]                rsp_bin_index,
   output logic [pcps_pkg::RANGE_W-1:0]              rsp_range_mm,
   output logic                                      rsp_range_valid
);
   import pcps_pkg::*;

   localparam int BIN_W  = $clog2(NUM_BINS);
   localparam int NB_W   = $clog2(NUM_BINS + 1);
   localparam int ENT_W  = RANGE_W + 1;
   localparam logic [NB_W-1:0] NB = NB_W'(NUM_BINS);

   // configuration
   logic signed [15:0] floor_ff, ceiling_ff;
   logic [15:0]        min_dist_ff, max_dist_ff;
   logic               clip_min_ff, clip_max_ff, keep_far_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff    <= 16'sd100;
         ceiling_ff  <= 16'sd2000;
         min_dist_ff <= 16'd100;
         max_dist_ff <= 16'd5000;
         clip_min_ff <= 1'b0;
         clip_max_ff <= 1'b0;
         keep_far_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FLOOR:    floor_ff    <= signed'(csr_wdata);
            CSR_CEILING:  ceiling_ff  <= signed'(csr_wdata);
            CSR_MIN_DIST: min_dist_ff <= csr_wdata;
            CSR_MAX_DIST: max_dist_ff <= csr_wdata;
            CSR_CLIP_MIN: clip_min_ff <= csr_wdata[0];
            CSR_CLIP_MAX: clip_max_ff <= csr_wdata[0];
            CSR_KEEP_FAR: keep_far_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // captured item
   logic [1:0]                func_ff;
   logic signed [COORD_W-1:0] x_ff, y_ff, z_ff;
   logic [SEL_W-1:0]          sel_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_func;
         x_ff    <= req_point_x;
         y_ff    <= req_point_y;
         z_ff    <= req_point_z;
         sel_ff  <= req_bin_select;
      end
   end

   assign status.func    = func_ff;
   assign status.in_band = (z_ff > floor_ff) && (z_ff < ceiling_ff);

   // squares, then root and cordic state
   logic signed [31:0]     xx_ff, yy_ff;
   logic [31:0]            n_ff;
   logic [19:0]            rem_ff;
   logic [15:0]            root_ff;
   logic signed [VEC_W-1:0] vx_ff, vy_ff;
   logic [31:0]            ang_ff;
   logic                   origin_ff;
   logic [BIN_W-1:0]       bin_ff;
   logic [RANGE_W-1:0]     dist_ff;

   logic signed [VEC_W-1:0] x_ext, y_ext, sx, sy;
   logic [19:0]            rem_sh, trial;
   logic [4:0]             step_i;
   logic [32+NB_W-1:0]     bin_prod;
   logic [RANGE_W-1:0]     d_clip;

   assign step_i = cnt[4:0];
   assign x_ext  = VEC_W'(x_ff);
   assign y_ext  = VEC_W'(y_ff);
   assign sx     = vx_ff >>> step_i;
   assign sy     = vy_ff >>> step_i;
   assign rem_sh = {rem_ff[17:0], n_ff[31:30]};
   assign trial  = {2'b00, root_ff, 2'b01};
   assign bin_prod = (32+NB_W)'(origin_ff ? 32'd0 : ang_ff) * (32+NB_W)'(NB);

   always_comb begin
      d_clip = root_ff;
      if (clip_min_ff && (root_ff < min_dist_ff)) begin
         d_clip = max_dist_ff;
      end
      if (clip_max_ff && !keep_far_ff && (d_clip > max_dist_ff)) begin
         d_clip = max_dist_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.square) begin
         xx_ff     <= x_ff * x_ff;
         yy_ff     <= y_ff * y_ff;
         origin_ff <= (x_ff == '0) && (y_ff == '0);
         // left half plane is folded over with a half turn
         if (x_ff < 0) begin
            vx_ff  <= (-x_ext) <<< CORDIC_SCALE;
            vy_ff  <= (-y_ext) <<< CORDIC_SCALE;
            ang_ff <= 32'h80000000;
         end else begin
            vx_ff  <= x_ext <<< CORDIC_SCALE;
            vy_ff  <= y_ext <<< CORDIC_SCALE;
            ang_ff <= 32'h00000000;
         end
      end
      if (cmd.sum) begin
         n_ff    <= unsigned'(xx_ff) + unsigned'(yy_ff);
         rem_ff  <= '0;
         root_ff <= '0;
      end
      if (cmd.step) begin
         if (vy_ff >= 0) begin
            vx_ff  <= vx_ff + sy;
            vy_ff  <= vy_ff - sx;
            ang_ff <= ang_ff + atan_turn(step_i);
         end else begin
            vx_ff  <= vx_ff - sy;
            vy_ff  <= vy_ff + sx;
            ang_ff <= ang_ff - atan_turn(step_i);
         end
         // one root bit per step over the first half of the iterations
         if (!step_i[4]) begin
            n_ff <= {n_ff[29:0], 2'b00};
            if (rem_sh >= trial) begin
               rem_ff  <= rem_sh - trial;
               root_ff <= {root_ff[14:0], 1'b1};
            end else begin
               rem_ff  <= rem_sh;
               root_ff <= {root_ff[14:0], 1'b0};
            end
         end
      end
      if (cmd.bin) begin
         bin_ff  <= BIN_W'(bin_prod[32+NB_W-1:32]);
         dist_ff <= d_clip;
      end
   end

   // bin store: filled flag over nearest range
   logic             ram_we;
   logic [BIN_W-1:0] ram_waddr, ram_raddr;
   logic [ENT_W-1:0] ram_wdata, ram_rdata;
   logic             take_new;
   logic             sel_ok;

   assign take_new  = !ram_rdata[RANGE_W] || (dist_ff < ram_rdata[RANGE_W-1:0]);
   assign ram_we    = cmd.wr_clr || (cmd.wr_acc && take_new);
   assign ram_waddr = cmd.wr_clr ? cnt[BIN_W-1:0] : bin_ff;
   assign ram_wdata = cmd.wr_clr ? '0 : {1'b1, dist_ff};
   assign ram_raddr = cmd.rd_sel ? BIN_W'(sel_ff) : bin_ff;
   assign sel_ok    = (32'(sel_ff) < NUM_BINS);

   pcps_ram #(
      .WIDTH (ENT_W),
      .DEPTH (NUM_BINS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // result word
   logic               strobe_ff;
   logic               acc_ff, valid_ff;
   logic [SEL_W-1:0]   idx_ff;
   logic [RANGE_W-1:0] range_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.rsp_point || cmd.rsp_read || cmd.rsp_zero;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_point) begin
         acc_ff   <= 1'b1;
         idx_ff   <= SEL_W'(bin_ff);
         range_ff <= dist_ff;
         valid_ff <= 1'b1;
      end else if (cmd.rsp_read) begin
         acc_ff   <= 1'b0;
         idx_ff   <= sel_ff;
         if (sel_ok && ram_rdata[RANGE_W]) begin
            range_ff <= ram_rdata[RANGE_W-1:0];
            valid_ff <= 1'b1;
         end else begin
            range_ff <= '0;
            valid_ff <= 1'b0;
         end
      end else if (cmd.rsp_zero) begin
         acc_ff   <= 1'b0;
         idx_ff   <= '0;
         range_ff <= '0;
         valid_ff <= 1'b0;
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_accepted    = acc_ff;
   assign rsp_bin_index   = idx_ff;
   assign rsp_range_mm    = range_ff;
   assign rsp_range_valid = valid_ff;

endmodule
`default_nettype wire

// File: dv/point_cloud_to_planar_scan_test.sv
// testbench for the planar scan block: random points, reads and clears checked against a predictor
`default_nettype none
module point_cloud_to_planar_scan_test;
   import pcps_pkg::*;

   localparam int NBINS = 360;
   localparam int IDLE_LIMIT = 4000;

   typedef struct {
      logic [1:0] func;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      logic [8:0] sel;
   } scan_word_type;

   typedef struct {
      logic accepted;
      logic [8:0] bin_index;
      logic [15:0] range_mm;
      logic range_valid;
   } scan_result_type;

   class scan_scoreboard;
      scan_result_type expected_q[$];
      int errors;
      int floor_mm, ceiling_mm;
      int unsigned min_mm, max_mm;
      bit near_clip, far_clip, keep_far;
      logic [15:0] nearest[NBINS];
      bit filled[NBINS];
      bit [31:0] atan_lut[32];

      function new();
         atan_lut = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
                      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
                      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
                      32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
                      32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
                      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
                      32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
                      32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000};
         errors = 0;
         floor_mm = 100;
         ceiling_mm = 2000;
         min_mm = 100;
         max_mm = 5000;
         near_clip = 0;
         far_clip = 0;
         keep_far = 0;
         foreach (filled[i]) filled[i] = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [15:0] val);
         case (idx)
            CSR_FLOOR:    floor_mm = $signed(val);
            CSR_CEILING:  ceiling_mm = $signed(val);
            CSR_MIN_DIST: min_mm = val;
            CSR_MAX_DIST: max_mm = val;
            CSR_CLIP_MIN: near_clip = val[0];
            CSR_CLIP_MAX: far_clip = val[0];
            CSR_KEEP_FAR: keep_far = val[0];
            default: ;
         endcase
      endfunction

      function int unsigned planar_distance(longint unsigned n);
         longint unsigned root, b;
         root = 0;
         b = 64'd1 << 62;
         while (b > n) b = b >> 2;
         while (b != 0) begin
            if (n >= root + b) begin
               n = n - (root + b);
               root = (root >> 1) + b;
            end else begin
               root = root >> 1;
            end
            b = b >> 2;
         end
         return int'(root);
      endfunction

      function bit [31:0] heading_turn(int px, int py);
         longint vx, vy, nx;
         bit [31:0] acc;
         acc = 0;
         if (px == 0 && py == 0) return 0;
         vx = px;
         vy = py;
         if (vx < 0) begin
            vx = -vx;
            vy = -vy;
            acc = 32'h80000000;
         end
         vx = vx * (64'sd1 << 30);
         vy = vy * (64'sd1 << 30);
         for (int i = 0; i < 32; i++) begin
            if (vy >= 0) begin
               nx = vx + (vy >>> i);
               vy = vy - (vx >>> i);
               acc = acc + atan_lut[i];
            end else begin
               nx = vx - (vy >>> i);
               vy = vy + (vx >>> i);
               acc = acc - atan_lut[i];
            end
            vx = nx;
         end
         return acc;
      endfunction

      function void note(scan_word_type w);
         scan_result_type r;
         int px, py, pz;
         int unsigned d, b;
         longint unsigned prod;
         r = '{1'b0, 9'd0, 16'd0, 1'b0};
         case (w.func)
            FN_POINT: begin
               px = w.x;
               py = w.y;
               pz = w.z;
               if (pz > floor_mm && pz < ceiling_mm) begin
                  d = planar_distance(longint'(px) * px + longint'(py) * py);
                  prod = {32'd0, heading_turn(px, py)} * 64'd360;
                  b = int'(prod >> 32);
                  if (b >= NBINS) b = NBINS - 1;
                  if (near_clip && d < min_mm) d = max_mm;
                  if (far_clip && !keep_far && d > max_mm) d = max_mm;
                  if (!filled[b] || d < nearest[b]) begin
                     nearest[b] = d[15:0];
                     filled[b] = 1;
                  end
                  r = '{1'b1, b[8:0], d[15:0], 1'b1};
               end
            end
            FN_READ: begin
               r.bin_index = w.sel;
               if (w.sel < NBINS && filled[w.sel]) begin
                  r.range_mm = nearest[w.sel];
                  r.range_valid = 1;
               end
            end
            FN_CLEAR: foreach (filled[i]) filled[i] = 0;
            default: ;
         endcase
         expected_q.insert(expected_q.size(), r);
      endfunction

      function void check(scan_result_type got);
         scan_result_type e;
         if (expected_q.size() == 0) begin
            $error("result with nothing expected");
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (got.accepted !== e.accepted) begin
            $error("accepted: expected %0d, got %0d", e.accepted, got.accepted);
            errors++;
         end
         if (got.bin_index !== e.bin_index) begin
            $error("bin_index: expected %0d, got %0d", e.bin_index, got.bin_index);
            errors++;
         end
         if (got.range_mm !== e.range_mm) begin
            $error("range_mm: expected %0d, got %0d", e.range_mm, got.range_mm);
            errors++;
         end
         if (got.range_valid !== e.range_valid) begin
            $error("range_valid: expected %0d, got %0d", e.range_valid, got.range_valid);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [1:0] req_func = FN_POINT;
   logic signed [15:0] req_point_x = 0, req_point_y = 0, req_point_z = 0;
   logic [8:0] req_bin_select = 0;
   logic csr_we = 0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_FLOOR;
   logic [15:0] csr_wdata = 0;
   logic rsp_strobe, rsp_accepted, rsp_range_valid;
   logic [8:0] rsp_bin_index;
   logic [15:0] rsp_range_mm;

   scan_scoreboard scan_sb = new();
   int idle_pct;
   int quiet_cycles = 0;

   point_cloud_to_planar_scan i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req_func), .req_point_x(req_point_x), .req_point_y(req_point_y),
      .req_point_z(req_point_z), .req_bin_select(req_bin_select),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .rsp_strobe(rsp_strobe), .rsp_accepted(rsp_accepted),
      .rsp_bin_index(rsp_bin_index), .rsp_range_mm(rsp_range_mm),
      .rsp_range_valid(rsp_range_valid)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         scan_sb.check('{rsp_accepted, rsp_bin_index, rsp_range_mm, rsp_range_valid});
   end

   // cycles with no word moving either way
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("** point_cloud_to_planar_scan: FAILED **");
            $finish;
         end
      end
   end

   task automatic send_word(scan_word_type w);
      while ($urandom_range(0, 99) < idle_pct) begin
         start = 0;
         @(negedge clock);
      end
      req_func = w.func;
      req_point_x = w.x;
      req_point_y = w.y;
      req_point_z = w.z;
      req_bin_select = w.sel;
      start = 1;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      scan_sb.note(w);
      @(negedge clock);
   endtask

   task automatic drain();
      start = 0;
      while (scan_sb.expected_q.size() != 0 || busy) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [15:0] val);
      csr_we = 1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 0;
      scan_sb.set_reg(idx, val);
   endtask

   task automatic setup(int fl, int ce, int mn, int mx, bit cmin, bit cmax, bit kf);
      drain();
      write_reg(CSR_FLOOR, fl[15:0]);
      write_reg(CSR_CEILING, ce[15:0]);
      write_reg(CSR_MIN_DIST, mn[15:0]);
      write_reg(CSR_MAX_DIST, mx[15:0]);
      write_reg(CSR_CLIP_MIN, {15'd0, cmin});
      write_reg(CSR_CLIP_MAX, {15'd0, cmax});
      write_reg(CSR_KEEP_FAR, {15'd0, kf});
   endtask

   function automatic scan_word_type mk(logic [1:0] f, int x, int y, int z, int s);
      scan_word_type w;
      w.func = f;
      w.x = x[15:0];
      w.y = y[15:0];
      w.z = z[15:0];
      w.sel = s[8:0];
      return w;
   endfunction

   function automatic int coord();
      if ($urandom_range(0, 2) == 0) return $signed(16'($urandom()));
      return $urandom_range(0, 12000) - 6000;
   endfunction

   task automatic random_words(int count);
      scan_word_type w;
      int pick, zv;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         zv = $signed(16'($urandom()));
         if (scan_sb.ceiling_mm - scan_sb.floor_mm >= 2 && $urandom_range(0, 99) < 85)
            zv = scan_sb.floor_mm + 1 +
                 $urandom_range(0, scan_sb.ceiling_mm - scan_sb.floor_mm - 2);
         if (pick < 62) w = mk(FN_POINT, coord(), coord(), zv, $urandom());
         else if (pick < 94) w = mk(FN_READ, $urandom(), $urandom(), $urandom(),
                                    $urandom_range(0, 511));
         else if (pick < 97) w = mk(FN_CLEAR, $urandom(), $urandom(), $urandom(), $urandom());
         else w = mk(2'd3, $urandom(), $urandom(), $urandom(), $urandom());
         if (pick >= 62 && pick < 85) w.sel = $urandom_range(0, NBINS - 1);
         send_word(w);
      end
   endtask

   initial begin
      idle_pct = 0;
      repeat (9) @(negedge clock);
      reset = 0;

      // defaults, then edge cases
      setup(100, 2000, 100, 5000, 0, 0, 0);
      send_word(mk(FN_READ, 0, 0, 0, 0));
      send_word(mk(FN_POINT, 0, 0, 500, 0));
      send_word(mk(FN_READ, 0, 0, 0, 0));
      send_word(mk(FN_POINT, -32768, -32768, 1000, 0));
      send_word(mk(FN_POINT, 32767, 32767, 1000, 0));
      send_word(mk(FN_POINT, -32768, 32767, 1000, 0));
      send_word(mk(FN_POINT, 32767, -32768, 1000, 0));
      send_word(mk(FN_POINT, -1, 0, 1000, 0));
      send_word(mk(FN_POINT, 0, -1, 1000, 0));
      send_word(mk(FN_POINT, 10, 10, 100, 0));
      send_word(mk(FN_POINT, 10, 10, 101, 0));
      send_word(mk(FN_POINT, 10, 10, 1999, 0));
      send_word(mk(FN_POINT, 10, 10, 2000, 0));
      send_word(mk(FN_POINT, 10, 10, -32768, 0));
      send_word(mk(FN_POINT, 10, 10, 32767, 0));
      send_word(mk(FN_READ, 0, 0, 0, 45));
      send_word(mk(FN_READ, 0, 0, 0, 359));
      send_word(mk(FN_READ, 0, 0, 0, 360));
      send_word(mk(FN_READ, 0, 0, 0, 511));
      send_word(mk(2'd3, -1, -1, -1, 511));
      send_word(mk(FN_CLEAR, 0, 0, 0, 0));
      send_word(mk(FN_READ, 0, 0, 0, 45));
      random_words(210);

      setup(-32768, 32767, 46341, 0, 1, 1, 0);
      idle_pct = 64;
      random_words(225);

      setup(-500, 500, 0, 46341, 1, 1, 1);
      idle_pct = 0;
      random_words(110);
      drain();
      random_words(115);

      setup(-1, 1, 3000, 3000, 1, 1, 0);
      idle_pct = 27;
      random_words(225);

      setup(200, 1800, 1500, 2500, 1, 0, 1);
      idle_pct = 64;
      random_words(225);

      setup(100, 2000, 0, 46341, 0, 1, 0);
      idle_pct = 0;
      random_words(225);

      drain();
      repeat (40) @(negedge clock);
      if (scan_sb.expected_q.size() != 0) begin
         $error("%0d results never arrived", scan_sb.expected_q.size());
         scan_sb.errors++;
      end
      if (scan_sb.errors == 0)
         $display("** point_cloud_to_planar_scan: PASSED **");
      else
         $display("** point_cloud_to_planar_scan: FAILED **");
      $finish;
   end
endmodule
`default_nettype wire

// File: filelist.f
rtl/core/pcps_pkg.sv
rtl/core/pcps_ram.sv
rtl/core/pcps_ctrl.sv
rtl/core/pcps_dp.sv
rtl/core/point_cloud_to_planar_scan.sv
dv/point_cloud_to_planar_scan_test.sv
